@@ hw/rtl/fpa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the fixed-point ALU.
// No dependencies.
package fpa_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned DividendW = 56;

  localparam logic [DataW-1:0] Int16Mask = 32'hffff0000;
  localparam logic [DataW-1:0] Frac16    = 32'h0000ffff;
  localparam logic [DataW-1:0] Int24Mask = 32'hff000000;
  localparam logic [DataW-1:0] Frac24    = 32'h00ffffff;

  typedef enum logic [4:0] {
    MODE_ADD       = 5'd0,
    MODE_ADD3      = 5'd1,
    MODE_SUB       = 5'd2,
    MODE_ABS       = 5'd3,
    MODE_MUL16     = 5'd4,
    MODE_DIV16     = 5'd5,
    MODE_DIVINT    = 5'd6,
    MODE_CEIL16    = 5'd7,
    MODE_FLOOR16   = 5'd8,
    MODE_MUL824    = 5'd9,
    MODE_MULMIX    = 5'd10,
    MODE_DIV824    = 5'd11,
    MODE_CEIL824   = 5'd12,
    MODE_FLOOR824  = 5'd13,
    MODE_INT_TO16  = 5'd14,
    MODE_F16_TOINT = 5'd15,
    MODE_INT_TO24  = 5'd16,
    MODE_F24_TOINT = 5'd17,
    MODE_F16_TO24  = 5'd18,
    MODE_F24_TO16  = 5'd19
  } mode_e;

  typedef enum logic [1:0] {
    SEL_DIRECT,
    SEL_MUL16,
    SEL_MUL24
  } sel_e;

  // dividend alignment for the divide modes
  typedef enum logic [1:0] {
    DIV_INT,
    DIV_Q16,
    DIV_Q24
  } div_fmt_e;

  typedef struct packed {
    logic [4:0]              mode;
    logic signed [DataW-1:0] operand_a;
    logic signed [DataW-1:0] operand_b;
    logic signed [DataW-1:0] operand_c;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] result;
    logic                    divide_by_zero;
  } out_item_t;

  typedef struct packed {
    logic             is_div;
    logic             dz;
    logic [DataW-1:0] direct;
  } side_t;

endpackage

@@ hw/rtl/fpa_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, low 32 quotient bits kept.
// Depends on fpa_pkg.
module fpa_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [fpa_pkg::DividendW-1:0] dividend_i,
  input  logic [fpa_pkg::DataW-1:0]   divisor_i,
  input  logic                        neg_i,
  input  fpa_pkg::side_t              side_i,
  output logic                        valid_o,
  output logic [fpa_pkg::DataW-1:0]   quot_o,
  output logic                        neg_o,
  output fpa_pkg::side_t              side_o
);
  import fpa_pkg::*;

  localparam int unsigned N = DividendW;

  typedef struct packed {
    logic [DataW-1:0]     rem;
    logic [DividendW-1:0] dvd;
    logic [DataW-1:0]     quo;
    logic [DataW-1:0]     dvs;
    logic                 neg;
    side_t                side;
  } stage_t;

  logic   v_q  [N];
  stage_t st_q [N];

  for (genvar i = 0; i < N; i++) begin : g_stage
    stage_t     src;
    logic       src_v;
    stage_t     nxt;
    logic [33:0] diff;
    logic        ge;

    if (i == 0) begin : g_first
      always_comb begin
        src_v    = valid_i;
        src.rem  = '0;
        src.dvd  = dividend_i;
        src.quo  = '0;
        src.dvs  = divisor_i;
        src.neg  = neg_i;
        src.side = side_i;
      end
    end else begin : g_rest
      always_comb begin
        src_v = v_q[i-1];
        src   = st_q[i-1];
      end
    end

    always_comb begin
      diff     = {1'b0, src.rem, src.dvd[DividendW-1]} - {2'b00, src.dvs};
      ge       = ~diff[33];
      nxt      = src;
      nxt.rem  = ge ? diff[DataW-1:0] : {src.rem[DataW-2:0], src.dvd[DividendW-1]};
      nxt.dvd  = {src.dvd[DividendW-2:0], 1'b0};
      nxt.quo  = {src.quo[DataW-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[i] <= nxt;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign quot_o  = st_q[N-1].quo;
  assign neg_o   = st_q[N-1].neg;
  assign side_o  = st_q[N-1].side;

endmodule

@@ hw/rtl/fixed_point_alu.sv @@
`timescale 1ns / 1ps
// 16.16 / 8.24 fixed-point ALU top level with valid/stall channels.
// Depends on fpa_pkg and fpa_div.
//
// Takes one item per cycle while the output is not stalled and returns one result per
// item, in order, through the same pipeline registers for every mode. The divider resolves one
// of its 56 quotient bits per pipeline stage; all other modes travel alongside it.
// A stall at the output holds the whole pipeline.
module fixed_point_alu (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fpa_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fpa_pkg::out_item_t  out_item_o
);
  import fpa_pkg::*;

  logic en;

  // stage 1: input register
  logic     v1_q;
  in_item_t in_q;

  // stage 2: multiply and operand prep
  logic                 v2_q;
  logic signed [63:0]   prod_q;
  sel_e                 sel_q;
  logic [DataW-1:0]     direct_q;
  logic                 is_div_q, dz_q, neg_q;
  logic [DataW-1:0]     amag_q, bmag_q;
  div_fmt_e             shift_q;

  // stage 3: select, feeds divider
  logic                 v3_q;
  side_t                side3_q;
  logic [DividendW-1:0] dvd3_q;
  logic [DataW-1:0]     dvs3_q;
  logic                 neg3_q;

  logic                 dv_valid, dv_neg;
  logic [DataW-1:0]     dv_quot;
  side_t                dv_side;

  logic      vout_q;
  out_item_t out_q;

  assign en         = ~(vout_q & out_stall_i);
  assign in_stall_o = ~en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      vout_q <= 1'b0;
    end else if (en) begin
      v1_q   <= in_valid_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      vout_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= in_item_i;
    end
  end

  logic [DataW-1:0] a, b, c, direct_d, amag_d, bmag_d;
  logic             is_div_d;
  sel_e             sel_d;
  div_fmt_e         shift_d;

  always_comb begin
    a        = in_q.operand_a;
    b        = in_q.operand_b;
    c        = in_q.operand_c;
    direct_d = '0;
    sel_d    = SEL_DIRECT;
    is_div_d = 1'b0;
    shift_d  = DIV_INT;
    case (in_q.mode) inside
      MODE_ADD:       direct_d = a + b;
      MODE_ADD3:      direct_d = a + b + c;
      MODE_SUB:       direct_d = a - b;
      MODE_ABS:       direct_d = a[DataW-1] ? (~a + 32'd1) : a;
      MODE_MUL16:     sel_d = SEL_MUL16;
      MODE_MUL824, MODE_MULMIX: sel_d = SEL_MUL24;
      MODE_DIV16:     begin is_div_d = 1'b1; shift_d = DIV_Q16; end
      MODE_DIVINT:    begin is_div_d = 1'b1; shift_d = DIV_INT; end
      MODE_DIV824:    begin is_div_d = 1'b1; shift_d = DIV_Q24; end
      MODE_CEIL16:    direct_d = (a + Frac16) & Int16Mask;
      MODE_FLOOR16:   direct_d = a & Int16Mask;
      MODE_CEIL824:   direct_d = (a + Frac24) & Int24Mask;
      MODE_FLOOR824:  direct_d = a & Int24Mask;
      MODE_INT_TO16:  direct_d = {a[15:0], 16'd0};
      MODE_F16_TOINT: direct_d = {{16{a[31]}}, a[31:16]};
      MODE_INT_TO24:  direct_d = {a[7:0], 24'd0};
      MODE_F24_TOINT: direct_d = {{24{a[31]}}, a[31:24]};
      MODE_F16_TO24:  direct_d = {a[23:0], 8'd0};
      MODE_F24_TO16:  direct_d = {{8{a[31]}}, a[31:8]};
      default:        direct_d = '0;
    endcase
    amag_d = a[DataW-1] ? (~a + 32'd1) : a;
    bmag_d = b[DataW-1] ? (~b + 32'd1) : b;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q   <= in_q.operand_a * in_q.operand_b;
      sel_q    <= sel_d;
      direct_q <= direct_d;
      is_div_q <= is_div_d;
      dz_q     <= is_div_d & (b == '0);
      neg_q    <= a[DataW-1] ^ b[DataW-1];
      amag_q   <= amag_d;
      bmag_q   <= bmag_d;
      shift_q  <= shift_d;
    end
  end

  logic [DataW-1:0]     sel_res;
  logic [DividendW-1:0] dvd_d;

  always_comb begin
    case (sel_q)
      SEL_MUL16: sel_res = prod_q[47:16];
      SEL_MUL24: sel_res = prod_q[55:24];
      default:   sel_res = direct_q;
    endcase
    case (shift_q)
      DIV_Q16: dvd_d = {8'd0, amag_q, 16'd0};
      DIV_Q24: dvd_d = {amag_q, 24'd0};
      default: dvd_d = {24'd0, amag_q};
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side3_q.is_div <= is_div_q;
      side3_q.dz     <= dz_q;
      side3_q.direct <= sel_res;
      dvd3_q         <= dvd_d;
      dvs3_q         <= bmag_q;
      neg3_q         <= neg_q;
    end
  end

  fpa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (v3_q),
    .dividend_i (dvd3_q),
    .divisor_i  (dvs3_q),
    .neg_i      (neg3_q),
    .side_i     (side3_q),
    .valid_o    (dv_valid),
    .quot_o     (dv_quot),
    .neg_o      (dv_neg),
    .side_o     (dv_side)
  );

  out_item_t out_d;

  always_comb begin
    out_d.divide_by_zero = dv_side.dz;
    if (!dv_side.is_div) begin
      out_d.result = dv_side.direct;
    end else if (dv_side.dz) begin
      out_d.result = '0;
    end else begin
      out_d.result = dv_neg ? (~dv_quot + 32'd1) : dv_quot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vout_q;
  assign out_item_o  = out_q;

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vout_q && out_q.divide_by_zero |-> out_q.result == '0)
    else $error("divide_by_zero with nonzero result");

  a_dz_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dz_q |-> is_div_q)
    else $error("zero-divisor flag outside divide modes");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(out_q) && $stable(v3_q))
    else $error("pipeline moved while held");

endmodule
